@@ design/wat_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_pkg
// Shared types and constants for the wildcard alarm table.
// ----------------------------------------------------------------------------
package wat_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PADDR_W     = 3;

  localparam logic [31:0] MIN_VALID_RST = 32'd100000;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;
  localparam logic [1:0] CMD_UPD  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_UPD  = 2'd2;
  localparam logic [1:0] KIND_FIRE = 2'd3;

  // one alarm entry as stored
  typedef struct packed {
    logic [15:0] id;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        enable;
    logic        repeat_en;
    logic        payload;
    logic        fired;
  } entry_t;

endpackage

@@ design/wildcard_alarm_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_alarm_table_top
// Ordered alarm table kept in a synchronous RAM, with add, delete, update
// and tick commands handled by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   cmd_i .. epoch_seconds_i
//  out       output     out_valid_o / out_ready_i kind_o ok_o result_id_o last_o
//  cfg       input      psel/penable/pwrite       paddr pwdata prdata (pready=1)
//
//  add writes the new entry on acceptance; delete and update scan the entries
//  up to the match, delete then moves each later entry down to close the gap.
//  a tick visits every entry in turn (read, then evaluate and write back).
//  one item at a time; a stalled output pauses a tick once two fires are queued.
//  reset zeroes count and stamp and sets next id to 1; RAM needs no clearing.
module wildcard_alarm_table_top
  import wat_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        task_id_i,
  input  logic [11:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  logic               enable_flag_i,
  input  logic               repeat_flag_i,
  input  logic               has_payload_i,
  input  logic [31:0]        epoch_seconds_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic               ok_o,
  output logic [15:0]        result_id_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIND_RD = 4'd1;
  localparam logic [3:0] S_FIND_EV = 4'd2;
  localparam logic [3:0] S_SHF_RD  = 4'd3;
  localparam logic [3:0] S_SHF_WR  = 4'd4;
  localparam logic [3:0] S_TICK_RD = 4'd5;
  localparam logic [3:0] S_TICK_EV = 4'd6;
  localparam logic [3:0] S_FLUSH   = 4'd7;
  localparam logic [3:0] S_RESP    = 4'd8;

  // control state
  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      next_id_q, next_id_d;
  logic [31:0]      stamp_q, stamp_d;
  logic [31:0]      min_valid_q;
  logic             pend_valid_q, pend_valid_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  logic [15:0] pend_id_q, pend_id_d;
  logic [1:0]  kind_q, kind_d;
  logic        ok_q, ok_d;
  logic [15:0] res_id_q, res_id_d;
  logic        last_q, last_d;
  logic [1:0]  rkind_q, rkind_d;
  logic        rok_q, rok_d;
  logic [15:0] rid_q, rid_d;

  // latched command
  logic [1:0]  cmd_q;
  entry_t      req_q;
  logic [15:0] tid_q;

  // memory
  entry_t           mem_q [TABLE_DEPTH];
  entry_t           rdata_q;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata;

  logic             in_acc, out_free, out_load;
  logic [1:0]       oload_kind;
  logic             oload_ok, oload_last;
  logic [15:0]      oload_id;
  logic [CNT_W-1:0] idx_ext, idx_nxt;
  logic             more;
  entry_t           in_entry;
  logic             match, fire, rearm, emit;
  entry_t           upd_entry;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign idx_ext    = {{(CNT_W-IDX_W){1'b0}}, idx_q};
  assign idx_nxt    = idx_ext + CNT_W'(1);
  assign more       = idx_nxt < count_q;

  // entry built from the input fields
  always_comb begin
    in_entry.id        = next_id_q;
    in_entry.year      = year_i;
    in_entry.month     = month_i;
    in_entry.day       = day_i;
    in_entry.hour      = hour_i;
    in_entry.minute    = minute_i;
    in_entry.second    = second_i;
    in_entry.enable    = enable_flag_i;
    in_entry.repeat_en = repeat_flag_i;
    in_entry.payload   = has_payload_i;
    in_entry.fired     = 1'b0;
  end

  // tick match on the entry just read
  always_comb begin
    match = ((rdata_q.year == '0) || (rdata_q.year == req_q.year)) &&
            ((rdata_q.month == '0) || (rdata_q.month == req_q.month)) &&
            ((rdata_q.day == '0) || (rdata_q.day == req_q.day)) &&
            (rdata_q.hour == req_q.hour) && (rdata_q.minute == req_q.minute) &&
            (req_q.second >= rdata_q.second);
    fire  = rdata_q.enable && match && !rdata_q.fired;
    rearm = rdata_q.enable && !match && rdata_q.fired && rdata_q.repeat_en;
    emit  = fire && rdata_q.payload;
    upd_entry = rdata_q;
    if (fire) begin
      upd_entry.fired = 1'b1;
      if (!rdata_q.repeat_en) begin
        upd_entry.enable = 1'b0;
      end
    end else if (rearm) begin
      upd_entry.fired = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    next_id_d    = next_id_q;
    stamp_d      = stamp_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    rkind_d      = rkind_q;
    rok_d        = rok_q;
    rid_d        = rid_q;
    we           = 1'b0;
    waddr        = idx_q;
    wdata        = rdata_q;
    raddr        = idx_q;
    out_load     = 1'b0;
    oload_kind   = KIND_FIRE;
    oload_ok     = 1'b1;
    oload_id     = pend_id_q;
    oload_last   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          rid_d = task_id_i;
          case (cmd_i)
            CMD_ADD: begin
              rkind_d = KIND_ADD;
              state_d = S_RESP;
              if (count_q >= CNT_W'(TABLE_DEPTH)) begin
                rok_d = 1'b0;
                rid_d = '0;
              end else begin
                we        = 1'b1;
                waddr     = count_q[IDX_W-1:0];
                wdata     = in_entry;
                count_d   = count_q + CNT_W'(1);
                rok_d     = 1'b1;
                rid_d     = next_id_q;
                next_id_d = next_id_q + 16'd1;
              end
            end
            CMD_DEL, CMD_UPD: begin
              rkind_d = (cmd_i == CMD_DEL) ? KIND_DEL : KIND_UPD;
              rok_d   = 1'b0;
              state_d = (count_q == '0) ? S_RESP : S_FIND_RD;
            end
            default: begin
              if ((count_q != '0) && (epoch_seconds_i >= min_valid_q) &&
                  (epoch_seconds_i != stamp_q)) begin
                stamp_d = epoch_seconds_i;
                state_d = S_TICK_RD;
              end
            end
          endcase
        end
      end
      S_FIND_RD: begin
        state_d = S_FIND_EV;
      end
      S_FIND_EV: begin
        if (rdata_q.id == tid_q) begin
          rok_d = 1'b1;
          if (cmd_q == CMD_UPD) begin
            we       = 1'b1;
            wdata    = req_q;
            wdata.id = tid_q;
            state_d  = S_RESP;
          end else if (more) begin
            state_d = S_SHF_RD;
          end else begin
            count_d = count_q - CNT_W'(1);
            state_d = S_RESP;
          end
        end else if (more) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_FIND_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SHF_RD: begin
        raddr   = idx_q + IDX_W'(1);
        state_d = S_SHF_WR;
      end
      S_SHF_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
        if (idx_nxt < count_q - CNT_W'(1)) begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = S_SHF_RD;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_RESP;
        end
      end
      S_TICK_RD: begin
        state_d = S_TICK_EV;
      end
      S_TICK_EV: begin
        // hold while a second result has nowhere to go
        if (!(emit && pend_valid_q && !out_free)) begin
          we    = 1'b1;
          wdata = upd_entry;
          if (emit) begin
            if (pend_valid_q) begin
              out_load = 1'b1;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = rdata_q.id;
          end
          if (more) begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_TICK_RD;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          oload_last   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          oload_kind = rkind_q;
          oload_ok   = rok_q;
          oload_id   = rid_q;
          oload_last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    ok_d        = ok_q;
    res_id_d    = res_id_q;
    last_d      = last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      kind_d      = oload_kind;
      ok_d        = oload_ok;
      res_id_d    = oload_id;
      last_d      = oload_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      count_q      <= '0;
      next_id_q    <= 16'd1;
      stamp_q      <= '0;
      min_valid_q  <= MIN_VALID_RST;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      count_q      <= count_d;
      next_id_q    <= next_id_d;
      stamp_q      <= stamp_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (psel && penable && pwrite && (paddr == '0)) begin
        min_valid_q <= pwdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_id_q <= pend_id_d;
    kind_q    <= kind_d;
    ok_q      <= ok_d;
    res_id_q  <= res_id_d;
    last_q    <= last_d;
    rkind_q   <= rkind_d;
    rok_q     <= rok_d;
    rid_q     <= rid_d;
    if (in_acc) begin
      cmd_q <= cmd_i;
      tid_q <= task_id_i;
      req_q <= in_entry;
    end
  end

  // entry ram, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign ok_o        = ok_q;
  assign result_id_o = res_id_q;
  assign last_o      = last_q;
  assign prdata      = (paddr == '0) ? min_valid_q : '0;
  assign pready      = 1'b1;

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("held fired item left behind at idle");

  a_resp_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESP) && (state_d == S_IDLE)) |=> (out_valid_q && last_q))
    else $error("command reply not presented");
`endif

endmodule

@@ tb/sv/wat_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wat_scoreboard
// Watches the command, reply and register ports of the alarm table, keeps
// its own copy of the table and register, works out the replies each
// accepted command should cause and compares them, in order, with the
// replies the block delivers.
// ----------------------------------------------------------------------------
module wat_scoreboard
  import wat_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        task_id_i,
  input  logic [11:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  logic               enable_flag_i,
  input  logic               repeat_flag_i,
  input  logic               has_payload_i,
  input  logic [31:0]        epoch_seconds_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         kind_i,
  input  logic               ok_i,
  input  logic [15:0]        result_id_i,
  input  logic               last_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [15:0] id;
    logic        last;
  } reply_t;

  entry_t      alarm_rows [TABLE_DEPTH];
  int          row_count;
  logic [15:0] next_alarm_id;
  logic [31:0] last_stamp;
  logic [31:0] min_valid;
  reply_t      replies_due [$];

  assign pending_o = replies_due.size();

  // first row holding the id, or -1
  function automatic int find_row(logic [15:0] id);
    for (int i = 0; i < row_count; i++)
      if (alarm_rows[i].id == id) return i;
    return -1;
  endfunction

  function automatic entry_t make_row(logic [15:0] id);
    entry_t e;
    e.id        = id;
    e.year      = year_i;
    e.month     = month_i;
    e.day       = day_i;
    e.hour      = hour_i;
    e.minute    = minute_i;
    e.second    = second_i;
    e.enable    = enable_flag_i;
    e.repeat_en = repeat_flag_i;
    e.payload   = has_payload_i;
    e.fired     = 1'b0;
    return e;
  endfunction

  // update the table copy for one command and queue its replies
  task automatic apply_command();
    int     pos;
    logic   hit;
    reply_t r;
    reply_t fired_q [$];
    case (cmd_i)
      CMD_ADD: begin
        if (row_count >= TABLE_DEPTH) begin
          r = '{KIND_ADD, 1'b0, 16'd0, 1'b1};
        end else begin
          alarm_rows[row_count] = make_row(next_alarm_id);
          row_count++;
          r = '{KIND_ADD, 1'b1, next_alarm_id, 1'b1};
          next_alarm_id++;
        end
        replies_due = {replies_due, r};
      end
      CMD_DEL: begin
        pos = find_row(task_id_i);
        if (pos >= 0) begin
          for (int i = pos; i + 1 < row_count; i++) alarm_rows[i] = alarm_rows[i+1];
          row_count--;
        end
        r = '{KIND_DEL, pos >= 0, task_id_i, 1'b1};
        replies_due = {replies_due, r};
      end
      CMD_UPD: begin
        pos = find_row(task_id_i);
        if (pos >= 0) alarm_rows[pos] = make_row(task_id_i);
        r = '{KIND_UPD, pos >= 0, task_id_i, 1'b1};
        replies_due = {replies_due, r};
      end
      default: begin
        // tick: skipped on empty table, unsynced clock or repeated stamp
        if (row_count != 0 && epoch_seconds_i >= min_valid &&
            epoch_seconds_i != last_stamp) begin
          last_stamp = epoch_seconds_i;
          for (int i = 0; i < row_count; i++) begin
            if (alarm_rows[i].enable) begin
              hit = (alarm_rows[i].year == 0 || alarm_rows[i].year == year_i) &&
                    (alarm_rows[i].month == 0 || alarm_rows[i].month == month_i) &&
                    (alarm_rows[i].day == 0 || alarm_rows[i].day == day_i) &&
                    alarm_rows[i].hour == hour_i && alarm_rows[i].minute == minute_i &&
                    second_i >= alarm_rows[i].second;
              if (hit && !alarm_rows[i].fired) begin
                alarm_rows[i].fired = 1'b1;
                if (alarm_rows[i].payload) begin
                  r = '{KIND_FIRE, 1'b1, alarm_rows[i].id, 1'b0};
                  fired_q = {fired_q, r};
                end
                if (!alarm_rows[i].repeat_en) alarm_rows[i].enable = 1'b0;
              end else if (!hit && alarm_rows[i].fired && alarm_rows[i].repeat_en) begin
                alarm_rows[i].fired = 1'b0;
              end
            end
          end
          if (fired_q.size() > 0) fired_q[fired_q.size()-1].last = 1'b1;
          replies_due = {replies_due, fired_q};
        end
      end
    endcase
  endtask

  // register writes, command prediction and reply comparison
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      row_count     = 0;
      next_alarm_id = 16'd1;
      last_stamp    = '0;
      min_valid     = MIN_VALID_RST;
      fail_count_o  = 0;
      replies_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == '0) min_valid = pwdata;
      if (in_valid_i && in_ready_i) apply_command();
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected reply kind=%0d ok=%0d id=%0d last=%0d", $time,
                   kind_i, ok_i, result_id_i, last_i);
        end else begin
          want = replies_due.pop_front();
          if (want.kind !== kind_i || want.ok !== ok_i || want.id !== result_id_i ||
              want.last !== last_i) begin
            fail_count_o++;
            $display("%0t: reply mismatch expected kind=%0d ok=%0d id=%0d last=%0d",
                     $time, want.kind, want.ok, want.id, want.last);
            $display("%0t:                  actual kind=%0d ok=%0d id=%0d last=%0d",
                     $time, kind_i, ok_i, result_id_i, last_i);
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_wildcard_alarm_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_alarm_table_top
// Drives commands and register writes into the alarm table: a directed
// opening, a full table, then random phases under several sync thresholds
// with random idling on both sides and stalls.
// ----------------------------------------------------------------------------
module tb_wildcard_alarm_table_top;
  import wat_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 2 * TABLE_DEPTH + 8;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         cmd_i = CMD_TICK;
  logic [15:0]        task_id_i = '0;
  logic [11:0]        year_i = '0;
  logic [3:0]         month_i = '0;
  logic [4:0]         day_i = '0;
  logic [4:0]         hour_i = '0;
  logic [5:0]         minute_i = '0;
  logic [5:0]         second_i = '0;
  logic               enable_flag_i = 1'b0;
  logic               repeat_flag_i = 1'b0;
  logic               has_payload_i = 1'b0;
  logic [31:0]        epoch_seconds_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic               ok_o;
  logic [15:0]        result_id_o;
  logic               last_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  bit          jitter = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          cycles = 0;
  logic [15:0] id_guess = 16'd1;
  logic [31:0] stamp = 32'd200000;

  always #5 clk_i = ~clk_i;

  wildcard_alarm_table_top u_dut (.*);

  wat_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .task_id_i,
    .year_i, .month_i, .day_i, .hour_i, .minute_i, .second_i, .enable_flag_i,
    .repeat_flag_i, .has_payload_i, .epoch_seconds_i, .out_valid_i(out_valid_o),
    .out_ready_i, .kind_i(kind_o), .ok_i(ok_o), .result_id_i(result_id_o),
    .last_i(last_o), .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // reply side: random back-pressure plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(jitter && $urandom_range(0, 99) < 17);
    end
  end

  // offer one command and wait for it to be taken; called at a falling edge
  task automatic send(input logic [1:0] cmd, input logic [15:0] tid, input logic [11:0] yr,
                      input logic [3:0] mo, input logic [4:0] dy, input logic [4:0] hr,
                      input logic [5:0] mi, input logic [5:0] sc, input logic en,
                      input logic rp, input logic pl, input logic [31:0] ep);
    if (jitter && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;  task_id_i <= tid;  year_i <= yr;  month_i <= mo;  day_i <= dy;
    hour_i <= hr;  minute_i <= mi;  second_i <= sc;  enable_flag_i <= en;
    repeat_flag_i <= rp;  has_payload_i <= pl;  epoch_seconds_i <= ep;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (cmd == CMD_ADD) id_guess++;
  endtask

  task automatic tick(input logic [11:0] yr, input logic [3:0] mo, input logic [4:0] dy,
                      input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] sc,
                      input logic [31:0] ep);
    send(CMD_TICK, 16'($urandom), yr, mo, dy, hr, mi, sc, 1'($urandom), 1'($urandom),
         1'($urandom), ep);
  endtask

  // hold new commands until every reply is in and the last tick has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_min_valid(input logic [31:0] value);
    psel <= 1'b1;  pwrite <= 1'b1;  paddr <= '0;  pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;  penable <= 1'b0;  pwrite <= 1'b0;
  endtask

  // random command: mostly entries and ticks that share a small time palette
  task automatic random_command();
    logic [1:0]  cmd;
    logic [15:0] tid;
    int          pick;
    pick = $urandom_range(0, 99);
    cmd  = (pick < 40) ? CMD_TICK : (pick < 65) ? CMD_ADD : (pick < 82) ? CMD_DEL : CMD_UPD;
    tid  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                       : 16'(id_guess - $urandom_range(1, 20));
    if ($urandom_range(0, 9) == 0) begin
      // noise over the full field widths
      send(cmd, 16'($urandom), 12'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
           6'($urandom), 6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
           $urandom);
    end else if (cmd == CMD_TICK) begin
      if ($urandom_range(0, 19) == 0) stamp = $urandom;
      else stamp += $urandom_range(0, 2);
      tick(12'd2024, 4'd3, 5'd7, 5'($urandom_range(0, 2)), 6'($urandom_range(0, 2)),
           6'($urandom_range(0, 8)), stamp);
    end else begin
      send(cmd, tid, $urandom_range(0, 1) ? 12'd2024 : 12'd0,
           $urandom_range(0, 1) ? 4'd3 : 4'd0, $urandom_range(0, 1) ? 5'd7 : 5'd0,
           5'($urandom_range(0, 2)), 6'($urandom_range(0, 2)), 6'($urandom_range(0, 5)),
           $urandom_range(0, 5) != 0, 1'($urandom), $urandom_range(0, 4) != 0, $urandom);
    end
  endtask

  initial begin
    logic [31:0] thresholds [4];
    thresholds = '{32'd100000, 32'd0, 32'hFFFF_FFFF, 32'd0};
    thresholds[3] = $urandom;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed opening
    tick(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd300000);              // empty table
    send(CMD_ADD, 16'd0, 12'd0, 4'd0, 5'd0, 5'd23, 6'd59, 6'd60, 1'b1, 1'b0, 1'b1, 32'd0);
    send(CMD_ADD, 16'hFFFF, 12'd4095, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 1'b1, 1'b1, 1'b1,
         '1);
    send(CMD_UPD, 16'hFFFF, 12'd1, 4'd1, 5'd1, 5'd1, 6'd1, 6'd1, 1'b1, 1'b1, 1'b1,
         32'd0);                                                          // unknown id
    send(CMD_DEL, 16'd0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0,
         32'd0);                                                          // unknown id
    tick(12'd4095, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 32'd99999);          // not synced
    tick(12'd4095, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0, 32'd200000);         // repeating fires
    tick(12'd4095, 4'd12, 5'd31, 5'd0, 6'd0, 6'd5, 32'd200000);         // same stamp
    tick(12'd4095, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd200001);      // re-arm, early
    tick(12'd2000, 4'd5, 5'd9, 5'd23, 6'd59, 6'd60, 32'd200002);        // one-shot fires
    tick(12'd4095, 4'd12, 5'd31, 5'd0, 6'd0, 6'd30, 32'd200003);        // fires again
    send(CMD_UPD, 16'd1, 12'd0, 4'd0, 5'd0, 5'd1, 6'd1, 6'd0, 1'b1, 1'b0, 1'b0, 32'd0);
    tick(12'd1, 4'd1, 5'd1, 5'd1, 6'd1, 6'd0, 32'd200004);              // silent match
    send(CMD_DEL, 16'd2, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 32'd0);

    // fill the table and overflow it
    repeat (TABLE_DEPTH + 1)
      send(CMD_ADD, 16'd0, 12'd0, 4'd0, 5'd0, 5'($urandom_range(0, 2)),
           6'($urandom_range(0, 2)), 6'd0, 1'b1, 1'($urandom), 1'b1, 32'd0);
    drain();

    // random phases, one sync threshold each
    for (int ph = 0; ph < 4; ph++) begin
      write_min_valid(thresholds[ph]);
      jitter = (ph != 1);
      for (int n = 0; n < 95; n++) begin
        if (ph == 0 && n == 20) hold_req = 1'b1;
        if (ph == 2 && n == 50) drain();
        if (ph == 2 && n % 10 == 0) tick(12'd2024, 4'd3, 5'd7, 5'd1, 6'd1, 6'd9, '1);
        random_command();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
